// File: rtl/htok_pkg.sv
// Package with the types, codes and character tables of the request header tokenizer.
package htok_pkg;

  localparam int unsigned POS_W = 13;
  localparam int unsigned MAX_BUFFER_BYTES = 1 << POS_W;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [1:0] KIND_REQUEST = 2'd0;
  localparam logic [1:0] KIND_HEADER  = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_METHOD = 3'd1;
  localparam logic [2:0] ST_NO_PATH    = 3'd2;
  localparam logic [2:0] ST_BAD_PROTO  = 3'd3;
  localparam logic [2:0] ST_NO_COLON   = 3'd4;

  localparam logic [1:0] METH_GET  = 2'd0;
  localparam logic [1:0] METH_POST = 2'd1;
  localparam logic [1:0] METH_HEAD = 2'd2;

  localparam logic [3:0] PROTO_LEN = 4'd8;

  typedef enum logic [3:0] {
    PH_START       = 4'd0,
    PH_METHOD      = 4'd1,
    PH_METHOD_DONE = 4'd2,
    PH_PREPATH     = 4'd3,
    PH_PATH        = 4'd4,
    PH_PREPROTO    = 4'd5,
    PH_PROTO       = 4'd6,
    PH_REQ_TAIL    = 4'd7,
    PH_HDR_GAP     = 4'd8,
    PH_HDR_LINE    = 4'd9,
    PH_IGNORE      = 4'd10
  } htok_phase_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [2:0]       status;
    logic [1:0]       method;
    logic [POS_W-1:0] first_start;
    logic [POS_W-1:0] first_len;
    logic [POS_W-1:0] second_start;
    logic [POS_W-1:0] second_len;
    logic             last;
  } htok_result_t;

  typedef struct packed {
    logic [1:0]   cnt;
    htok_result_t r0;
    htok_result_t r1;
  } htok_push_t;

  function automatic logic [2:0] meth_len(input logic [1:0] m);
    logic [2:0] len;
    unique case (m)
      METH_GET: len = 3'd3;
      default:  len = 3'd4;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] meth_char(input logic [1:0] m, input logic [1:0] idx);
    logic [7:0] ch;
    unique case (m)
      METH_GET: begin
        unique case (idx)
          2'd0: ch = "G";
          2'd1: ch = "E";
          2'd2: ch = "T";
          default: ch = 8'h00;
        endcase
      end
      METH_POST: begin
        unique case (idx)
          2'd0: ch = "P";
          2'd1: ch = "O";
          2'd2: ch = "S";
          default: ch = "T";
        endcase
      end
      default: begin
        unique case (idx)
          2'd0: ch = "H";
          2'd1: ch = "E";
          2'd2: ch = "A";
          default: ch = "D";
        endcase
      end
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] proto_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0: ch = "H";
      3'd1: ch = "T";
      3'd2: ch = "T";
      3'd3: ch = "P";
      3'd4: ch = "/";
      3'd5: ch = "1";
      3'd6: ch = ".";
      default: ch = "1";
    endcase
    return ch;
  endfunction

endpackage

// File: rtl/htok_if.sv
// Channel interfaces for header bytes and tokenizer results.
interface htok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface htok_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  status;
  logic [1:0]  method;
  logic [12:0] first_start;
  logic [12:0] first_len;
  logic [12:0] second_start;
  logic [12:0] second_len;
  logic        last;

  modport source (output valid, output kind, output status, output method,
                  output first_start, output first_len, output second_start,
                  output second_len, output last, input ready);
  modport sink (input valid, input kind, input status, input method,
                input first_start, input first_len, input second_start,
                input second_len, input last, output ready);
endinterface

// File: rtl/htok_parser.sv
// Byte-level parser state and the results that each accepted word causes.
module htok_parser import htok_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       end_of_buffer,
  output htok_push_t push
);

  htok_phase_t      phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [3:0]       match_r, match_nxt;
  logic [2:0]       cand_r, cand_nxt;
  logic [1:0]       method_r, method_nxt;
  logic [POS_W-1:0] path_begin_r, path_begin_nxt;
  logic [POS_W-1:0] path_size_r, path_size_nxt;
  logic [POS_W-1:0] tok_begin_r, tok_begin_nxt;
  logic [POS_W-1:0] tok_last_r, tok_last_nxt;
  logic             tok_has_r, tok_has_nxt;
  logic [POS_W-1:0] key_begin_r, key_begin_nxt;
  logic [POS_W-1:0] key_len_r, key_len_nxt;
  logic             colon_r, colon_nxt;

  logic             eol;
  logic             is_space;
  htok_phase_t      ph_e;
  logic [2:0]       keep;
  logic [3:0]       match_inc;
  logic             found_any;
  logic [1:0]       found_idx;
  logic [3:0]       proto_idx;
  logic [3:0]       proto_inc;
  logic             proto_ok;
  logic             hdr_new;
  logic [POS_W-1:0] tb_e, tl_e;
  logic             th_e, colon_e;
  logic [POS_W-1:0] tok_len_e;
  logic [POS_W-1:0] pos_inc;
  logic             a_valid;
  htok_result_t     res_a, res_end;

  assign eol      = end_of_buffer || data_byte == CH_CR || data_byte == CH_LF;
  assign is_space = data_byte == CH_SPACE;
  assign pos_inc  = pos_r + 1'b1;
  assign hdr_new  = phase_r == PH_HDR_GAP && !eol;

  always_comb begin
    ph_e = phase_r;
    if (phase_r == PH_START && !eol) begin
      ph_e = PH_METHOD;
    end else if (hdr_new) begin
      ph_e = PH_HDR_LINE;
    end
  end

  always_comb begin
    keep      = '0;
    found_any = 1'b0;
    found_idx = METH_GET;
    match_inc = match_r + 4'd1;
    for (int c = 0; c < 3; c++) begin
      keep[c] = cand_r[c] && (match_r < {1'b0, meth_len(2'(c))})
                && meth_char(2'(c), match_r[1:0]) == data_byte;
      if (keep[c] && {1'b0, meth_len(2'(c))} == match_inc) begin
        found_any = 1'b1;
        found_idx = 2'(c);
      end
    end
  end

  assign proto_idx = (phase_r == PH_PREPROTO) ? 4'd0 : match_r;
  assign proto_inc = proto_idx + 4'd1;
  assign proto_ok  = proto_idx < PROTO_LEN && proto_char(proto_idx[2:0]) == data_byte;

  assign tb_e      = hdr_new ? pos_r : tok_begin_r;
  assign tl_e      = hdr_new ? pos_r : tok_last_r;
  assign th_e      = hdr_new ? 1'b0 : tok_has_r;
  assign colon_e   = hdr_new ? 1'b0 : colon_r;
  assign tok_len_e = th_e ? POS_W'(tl_e - tb_e + 1'b1) : '0;

  // Next state.
  always_comb begin
    phase_nxt      = phase_r;
    pos_nxt        = pos_inc;
    match_nxt      = match_r;
    cand_nxt       = cand_r;
    method_nxt     = method_r;
    path_begin_nxt = path_begin_r;
    path_size_nxt  = path_size_r;
    tok_begin_nxt  = tb_e;
    tok_last_nxt   = tl_e;
    tok_has_nxt    = th_e;
    key_begin_nxt  = hdr_new ? '0 : key_begin_r;
    key_len_nxt    = hdr_new ? '0 : key_len_r;
    colon_nxt      = colon_e;
    unique case (ph_e)
      PH_START: begin
      end
      PH_METHOD: begin
        if (eol) begin
          phase_nxt = PH_IGNORE;
        end else begin
          cand_nxt = keep;
          if (keep == '0) begin
            phase_nxt = PH_IGNORE;
          end else begin
            match_nxt = match_inc;
            if (found_any) begin
              method_nxt = found_idx;
              phase_nxt  = PH_METHOD_DONE;
            end
          end
        end
      end
      PH_METHOD_DONE, PH_PREPATH: begin
        if (eol) begin
          phase_nxt = PH_IGNORE;
        end else if (is_space) begin
          phase_nxt = PH_PREPATH;
        end else begin
          path_begin_nxt = pos_r;
          phase_nxt      = PH_PATH;
        end
      end
      PH_PATH: begin
        if (eol) begin
          phase_nxt = PH_IGNORE;
        end else if (is_space) begin
          path_size_nxt = pos_r - path_begin_r;
          phase_nxt     = PH_PREPROTO;
        end
      end
      PH_PREPROTO, PH_PROTO: begin
        if (eol) begin
          phase_nxt = PH_IGNORE;
        end else if (!(phase_r == PH_PREPROTO && is_space)) begin
          if (!proto_ok) begin
            phase_nxt = PH_IGNORE;
          end else begin
            match_nxt = proto_inc;
            phase_nxt = (proto_inc == PROTO_LEN) ? PH_REQ_TAIL : PH_PROTO;
          end
        end
      end
      PH_REQ_TAIL: begin
        if (eol) begin
          phase_nxt = PH_HDR_GAP;
        end
      end
      PH_HDR_GAP: begin
      end
      PH_HDR_LINE: begin
        if (eol) begin
          phase_nxt = PH_HDR_GAP;
        end else begin
          phase_nxt = PH_HDR_LINE;
          if (data_byte == CH_COLON && !colon_e) begin
            key_begin_nxt = tb_e;
            key_len_nxt   = tok_len_e;
            colon_nxt     = 1'b1;
            tok_begin_nxt = pos_inc;
            tok_last_nxt  = pos_inc;
            tok_has_nxt   = 1'b0;
          end else if (!is_space) begin
            if (!th_e) begin
              tok_begin_nxt = pos_r;
            end
            tok_has_nxt  = 1'b1;
            tok_last_nxt = pos_r;
          end
        end
      end
      PH_IGNORE: begin
      end
      default: begin
      end
    endcase
    if (end_of_buffer) begin
      phase_nxt      = PH_START;
      pos_nxt        = '0;
      match_nxt      = '0;
      cand_nxt       = '1;
      method_nxt     = METH_GET;
      path_begin_nxt = '0;
      path_size_nxt  = '0;
      tok_begin_nxt  = '0;
      tok_last_nxt   = '0;
      tok_has_nxt    = 1'b0;
      key_begin_nxt  = '0;
      key_len_nxt    = '0;
      colon_nxt      = 1'b0;
    end
  end

  // Results.
  always_comb begin
    a_valid = 1'b0;
    res_a   = '0;
    unique case (ph_e)
      PH_START: begin
        if (end_of_buffer) begin
          a_valid      = 1'b1;
          res_a.status = ST_BAD_METHOD;
        end
      end
      PH_METHOD: begin
        if (eol || keep == '0) begin
          a_valid      = 1'b1;
          res_a.status = ST_BAD_METHOD;
        end
      end
      PH_METHOD_DONE: begin
        if (eol) begin
          a_valid      = 1'b1;
          res_a.status = ST_BAD_METHOD;
        end
      end
      PH_PREPATH, PH_PATH: begin
        if (eol) begin
          a_valid      = 1'b1;
          res_a.status = ST_NO_PATH;
          res_a.method = method_r;
        end
      end
      PH_PREPROTO, PH_PROTO: begin
        if (eol) begin
          a_valid      = 1'b1;
          res_a.status = ST_BAD_PROTO;
          res_a.method = method_r;
        end else if (!(phase_r == PH_PREPROTO && is_space)) begin
          if (!proto_ok) begin
            a_valid      = 1'b1;
            res_a.status = ST_BAD_PROTO;
            res_a.method = method_r;
          end else if (proto_inc == PROTO_LEN) begin
            a_valid           = 1'b1;
            res_a.status      = ST_OK;
            res_a.method      = method_r;
            res_a.first_start = path_begin_r;
            res_a.first_len   = path_size_r;
          end
        end
      end
      PH_HDR_LINE: begin
        if (eol) begin
          a_valid    = 1'b1;
          res_a.kind = KIND_HEADER;
          if (!colon_r) begin
            res_a.status = ST_NO_COLON;
          end else begin
            res_a.status       = ST_OK;
            res_a.first_start  = key_begin_r;
            res_a.first_len    = key_len_r;
            res_a.second_start = tok_begin_r;
            res_a.second_len   = tok_len_e;
          end
        end
      end
      PH_REQ_TAIL, PH_HDR_GAP, PH_IGNORE: begin
      end
      default: begin
      end
    endcase

    res_end      = '0;
    res_end.kind = KIND_END;
    res_end.last = 1'b1;

    push = '0;
    if (accept) begin
      if (a_valid && end_of_buffer) begin
        push.cnt = 2'd2;
        push.r0  = res_a;
        push.r1  = res_end;
      end else if (a_valid) begin
        push.cnt     = 2'd1;
        push.r0      = res_a;
        push.r0.last = 1'b1;
      end else if (end_of_buffer) begin
        push.cnt = 2'd1;
        push.r0  = res_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_START;
      pos_r        <= '0;
      match_r      <= '0;
      cand_r       <= '1;
      method_r     <= METH_GET;
      path_begin_r <= '0;
      path_size_r  <= '0;
      tok_begin_r  <= '0;
      tok_last_r   <= '0;
      tok_has_r    <= 1'b0;
      key_begin_r  <= '0;
      key_len_r    <= '0;
      colon_r      <= 1'b0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      pos_r        <= pos_nxt;
      match_r      <= match_nxt;
      cand_r       <= cand_nxt;
      method_r     <= method_nxt;
      path_begin_r <= path_begin_nxt;
      path_size_r  <= path_size_nxt;
      tok_begin_r  <= tok_begin_nxt;
      tok_last_r   <= tok_last_nxt;
      tok_has_r    <= tok_has_nxt;
      key_begin_r  <= key_begin_nxt;
      key_len_r    <= key_len_nxt;
      colon_r      <= colon_nxt;
    end
  end

endmodule

// File: rtl/htok_result_queue.sv
// Small result queue that takes up to two results per cycle and hands out one.
module htok_result_queue import htok_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  htok_push_t   push,
  output logic         space_ok,
  output logic         head_valid,
  input  logic         head_ready,
  output htok_result_t head
);

  htok_result_t      mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              pop;
  logic [QPTR_W-1:0] wr_ptr_inc;

  assign space_ok   = cnt_r <= QCNT_W'(QUEUE_DEPTH - 2);
  assign head_valid = cnt_r != '0;
  assign head       = mem_r[rd_ptr_r];
  assign pop        = head_valid && head_ready;
  assign wr_ptr_inc = wr_ptr_r + 1'b1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    cnt_nxt    = cnt_r + QCNT_W'(push.cnt) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_inc] <= push.r1;
    end
  end

endmodule

// File: rtl/http_request_header_tokenizer_core.sv
// Top level of the request header tokenizer.
//
//   Channel  Direction  Word
//   in_ch    sink       data_byte, end_of_buffer
//   out_ch   source     kind, status, method, first/second start and len, last
//
// One byte is taken per cycle while the result queue has room; its results are in the result queue from the next cycle.
// A byte yields at most two results: a line result and the end result.
// The input is ready while the four-entry result queue has room for two results.
// Reset is synchronous on rst_n and returns the parser to the start of a buffer.
// A stalled output only stops the input once the queue is nearly full.
module http_request_header_tokenizer_core import htok_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  htok_in_if.sink    in_ch,
  htok_out_if.source out_ch
);

  logic         accept;
  logic         space_ok;
  logic         head_valid;
  htok_push_t   push;
  htok_result_t head;

  assign in_ch.ready = space_ok;
  assign accept      = in_ch.valid && space_ok;

  htok_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .data_byte     (in_ch.data_byte),
    .end_of_buffer (in_ch.end_of_buffer),
    .push          (push)
  );

  htok_result_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .space_ok   (space_ok),
    .head_valid (head_valid),
    .head_ready (out_ch.ready),
    .head       (head)
  );

  assign out_ch.valid        = head_valid;
  assign out_ch.kind         = head.kind;
  assign out_ch.status       = head.status;
  assign out_ch.method       = head.method;
  assign out_ch.first_start  = head.first_start;
  assign out_ch.first_len    = head.first_len;
  assign out_ch.second_start = head.second_start;
  assign out_ch.second_len   = head.second_len;
  assign out_ch.last         = head.last;

endmodule

// File: rtl/htok_checker.sv
// Port-level checker for the tokenizer and its bind to the top level.
module htok_checker import htok_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_end_of_buffer,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [2:0]  out_status,
  input logic [12:0] out_first_start,
  input logic [12:0] out_second_len,
  input logic        out_last
);

  // A result that is not taken stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  // The end of a buffer always produces a result.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end_of_buffer |=> out_valid)
    else $error("no result after end of buffer");

  // An end result is the last one of its word and carries no offsets.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_END |->
      out_last && out_status == ST_OK && out_first_start == '0 && out_second_len == '0)
    else $error("malformed end result");

  // Error results carry no offsets.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_first_start == '0 && out_second_len == '0)
    else $error("error result with offsets");

endmodule

bind http_request_header_tokenizer_core htok_checker u_htok_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_end_of_buffer (in_ch.end_of_buffer),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_kind         (out_ch.kind),
  .out_status       (out_ch.status),
  .out_first_start  (out_ch.first_start),
  .out_second_len   (out_ch.second_len),
  .out_last         (out_ch.last)
);
